/* rtl/associated_legendre_eval_core_macros.svh */
// Assertion macros for the associated Legendre evaluator.
// Used by the port-level checker; no dependencies.
`ifndef ASSOCIATED_LEGENDRE_EVAL_CORE_MACROS_SVH
`define ASSOCIATED_LEGENDRE_EVAL_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ALE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ALE_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/ale_pkg.sv */
// Shared constants and helpers for the associated Legendre evaluator.
// No dependencies.
package ale_pkg;

   localparam int unsigned DEG_W   = 3;
   localparam int unsigned X_W     = 32;
   localparam int unsigned VAL_W   = 48;
   localparam int unsigned RAD_W   = 61;   // 1 - x^2 in Q1.60
   localparam int unsigned ROOT_W  = 31;   // sin(theta) in Q1.30
   localparam int unsigned MAG_W   = 51;   // |P| * small integer
   localparam int unsigned NUM_W   = 55;   // divider operand
   localparam int unsigned EXT_W   = 56;   // signed working width

   localparam logic [DEG_W-1:0] MAX_DEGREE = 3'd7;

   localparam logic signed [VAL_W-1:0] ONE_Q28 = 48'sd268435456;
   localparam logic signed [EXT_W-1:0] SAT_HI  = 56'sd140737488355327;
   localparam logic signed [EXT_W-1:0] SAT_LO  = -56'sd140737488355328;

   function automatic logic signed [VAL_W-1:0] sat48(input logic signed [EXT_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[VAL_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [DEG_W-1:0] clamp_deg(input logic [DEG_W-1:0] d);
      return (d > MAX_DEGREE) ? MAX_DEGREE : d;
   endfunction

endpackage

/* rtl/ale_mul32.sv */
// Shared 32x32 unsigned multiplier with registered product.
// Depends on ale_pkg.
module ale_mul32
   import ale_pkg::*;
(
   input  logic              clock,
   input  logic [X_W-1:0]    op_a,
   input  logic [X_W-1:0]    op_b,
   output logic [2*X_W-1:0]  prod_ff
);

   logic [2*X_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* rtl/ale_isqrt.sv */
// Bit-pair restoring integer square root, one result bit per cycle.
// Depends on ale_pkg.
module ale_isqrt
   import ale_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done_ff,
   output logic [ROOT_W-1:0] root
);

   logic              busy_ff, busy_in, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [RAD_W-1:0]  v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [RAD_W:0]    trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign root  = res_ff[ROOT_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd30;
         v_in    = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 1);
      end else if (busy_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in   = v_ff - trial[RAD_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

endmodule

/* rtl/ale_sdiv.sv */
// Restoring serial divider by a small divisor, one quotient bit per cycle.
// Depends on ale_pkg.
module ale_sdiv
   import ale_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [2:0]       den,
   output logic             done_ff,
   output logic [NUM_W-1:0] quo
);

   logic             busy_ff, busy_in, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [2:0]       rem_ff, rem_in, den_ff, den_in;
   logic [3:0]       shifted;

   assign shifted = {rem_ff, q_ff[NUM_W-1]};
   assign quo     = q_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(NUM_W - 1);
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 3'(shifted - {1'b0, den_ff});
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[2:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

/* rtl/associated_legendre_eval_core.sv */
// Associated Legendre P_l^m(x) evaluator, one item at a time.
// Most of each item's time goes to the square root wait and to the serial
// divide wait of each recurrence step; order > degree skips both and goes
// straight to ST_FIN, and a stalled result holds back the next one. req_ready
// is high only when idle, so an item is taken only once the last is issued.
// Reset (synchronous) returns to idle and drops rsp_valid.
module associated_legendre_eval_core
   import ale_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [DEG_W-1:0]        req_degree,
   input  logic [DEG_W-1:0]        req_order,
   input  logic signed [X_W-1:0]   req_cos_theta,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic                    rsp_order_too_high
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_MUL, ST_SQ_RAD, ST_SQRT, ST_PM_CHK, ST_MQ_K, ST_MQ_LO,
      ST_MQ_HI, ST_MQ_SUM, ST_DIV_NUM, ST_DIV_GO, ST_DIV_WAIT, ST_REC_CHK, ST_FIN
   } state_type;

   // which product the shared multiply sequence is serving
   typedef enum logic [1:0] {PH_PMM, PH_P1, PH_REC} phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [DEG_W-1:0]        l_ff, l_in, m_ff, m_in;
   logic [DEG_W:0]          n_ff, n_in;
   logic [X_W-1:0]          ux_ff, ux_in, ub_ff, ub_in;
   logic                    xneg_ff, xneg_in, neg_ff, neg_in, dneg_ff, dneg_in;
   logic [ROOT_W-1:0]       s_ff, s_in;
   logic signed [VAL_W-1:0] p0_ff, p0_in, p1_ff, p1_in, fin_val_ff, fin_val_in;
   logic                    fin_flag_ff, fin_flag_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [34:0]             lo_ff, lo_in;
   logic signed [EXT_W-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [2:0]              den_ff, den_in;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_flag_ff, rsp_flag_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // shared datapath signals
   logic [X_W-1:0]          mul_a, mul_b;
   logic [2*X_W-1:0]        prod_ff;
   logic signed [VAL_W-1:0] sm_p;
   logic [4:0]              sm_k;
   logic signed [53:0]      sm_prod;
   logic [EXT_W-1:0]        mq_mag;
   logic signed [EXT_W-1:0] mq_val, diff, qs;
   logic [EXT_W-1:0]        dmag;
   logic [RAD_W-1:0]        rad;
   logic                    sqrt_go, sqrt_done, div_go, div_done;
   logic [ROOT_W-1:0]       root;
   logic [NUM_W-1:0]        quo;
   logic                    out_free;

   ale_mul32 u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   ale_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_go),
      .radicand (rad),
      .done_ff  (sqrt_done),
      .root     (root)
   );

   ale_sdiv u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_go),
      .num     (num_ff),
      .den     (den_ff),
      .done_ff (div_done),
      .quo     (quo)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_order_too_high = rsp_flag_ff;
   assign out_free           = !rsp_valid_ff || rsp_ready;

   // big multiplier: x^2, then low and high halves of |P*k| * |b|
   always_comb begin
      case (state_ff)
         ST_SQ_MUL: begin
            mul_a = ux_ff;
            mul_b = ux_ff;
         end
         ST_MQ_LO: begin
            mul_a = mag_ff[X_W-1:0];
            mul_b = ub_ff;
         end
         ST_MQ_HI: begin
            mul_a = X_W'(mag_ff[MAG_W-1:X_W]);
            mul_b = ub_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // small multiplier: P times an integer coefficient
   always_comb begin
      if (state_ff == ST_MQ_LO) begin
         sm_p = p0_ff;
         sm_k = 5'({1'b0, n_ff} + {2'b0, m_ff} - 5'd1);
      end else begin
         sm_p = (phase_ff == PH_REC) ? p1_ff : p0_ff;
         if (phase_ff == PH_P1) begin
            sm_k = 5'({m_ff, 1'b1});
         end else begin
            sm_k = 5'({n_ff, 1'b0} - 5'd1);
         end
      end
   end
   assign sm_prod = sm_p * $signed({1'b0, sm_k});

   // 1 - x^2, clamped at zero when |x| > 1
   assign rad = (prod_ff < (64'd1 << 60)) ? RAD_W'((64'd1 << 60) - prod_ff) : '0;

   // rounded Q.30 product: high partial (x4) plus rounded low partial
   assign mq_mag = {prod_ff[53:0], 2'b00} + EXT_W'(lo_ff);
   assign mq_val = neg_ff ? $signed(EXT_W'(0) - mq_mag) : $signed(mq_mag);

   assign diff = t1_ff - t2_ff;
   assign dmag = diff[EXT_W-1] ? EXT_W'(0) - diff : diff;
   assign qs   = dneg_ff ? $signed(EXT_W'(0) - {1'b0, quo}) : $signed({1'b0, quo});

   assign sqrt_go = (state_ff == ST_SQ_RAD);
   assign div_go  = (state_ff == ST_DIV_GO);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      l_in         = l_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      ux_in        = ux_ff;
      ub_in        = ub_ff;
      xneg_in      = xneg_ff;
      neg_in       = neg_ff;
      dneg_in      = dneg_ff;
      s_in         = s_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      fin_val_in   = fin_val_ff;
      fin_flag_in  = fin_flag_ff;
      mag_in       = mag_ff;
      lo_in        = lo_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_order > req_degree) begin
                  fin_val_in  = '0;
                  fin_flag_in = 1'b1;
                  state_in    = ST_FIN;
               end else begin
                  fin_flag_in = 1'b0;
                  l_in        = clamp_deg(req_degree);
                  m_in        = clamp_deg(req_order);
                  xneg_in     = req_cos_theta[X_W-1];
                  ux_in       = req_cos_theta[X_W-1] ? X_W'(0) - X_W'(req_cos_theta)
                                                     : X_W'(req_cos_theta);
                  state_in    = ST_SQ_MUL;
               end
            end
         end
         ST_SQ_MUL: begin
            state_in = ST_SQ_RAD;
         end
         ST_SQ_RAD: begin
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               s_in     = root;
               p0_in    = ONE_Q28;
               n_in     = (DEG_W+1)'(1);
               state_in = ST_PM_CHK;
            end
         end
         ST_PM_CHK: begin
            if (n_ff <= {1'b0, m_ff}) begin
               phase_in = PH_PMM;
               state_in = ST_MQ_K;
            end else if (l_ff == m_ff) begin
               fin_val_in = p0_ff;
               state_in   = ST_FIN;
            end else begin
               phase_in = PH_P1;
               state_in = ST_MQ_K;
            end
         end
         ST_MQ_K: begin
            mag_in   = MAG_W'(sm_prod[53] ? 54'sd0 - sm_prod : sm_prod);
            ub_in    = (phase_ff == PH_PMM) ? X_W'(s_ff) : ux_ff;
            neg_in   = sm_p[VAL_W-1] ^ ((phase_ff != PH_PMM) && xneg_ff);
            state_in = ST_MQ_LO;
         end
         ST_MQ_LO: begin
            t2_in    = EXT_W'(sm_prod);
            state_in = ST_MQ_HI;
         end
         ST_MQ_HI: begin
            lo_in    = 35'(({1'b0, prod_ff} + (65'd1 << 29)) >> 30);
            state_in = ST_MQ_SUM;
         end
         ST_MQ_SUM: begin
            case (phase_ff)
               PH_PMM: begin
                  p0_in    = sat48(mq_val);
                  n_in     = n_ff + (DEG_W+1)'(1);
                  state_in = ST_PM_CHK;
               end
               PH_P1: begin
                  p1_in    = sat48(mq_val);
                  n_in     = {1'b0, m_ff} + (DEG_W+1)'(2);
                  state_in = ST_REC_CHK;
               end
               default: begin
                  t1_in    = mq_val;
                  state_in = ST_DIV_NUM;
               end
            endcase
         end
         ST_DIV_NUM: begin
            // t1 and t2 are both registered now: |t1 - t2| + den/2 for the
            // rounded divide, sign kept aside
            num_in   = NUM_W'(dmag) + NUM_W'(den_ff >> 1);
            dneg_in  = diff[EXT_W-1];
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               p0_in    = p1_ff;
               p1_in    = sat48(qs);
               n_in     = n_ff + (DEG_W+1)'(1);
               state_in = ST_REC_CHK;
            end
         end
         ST_REC_CHK: begin
            if (n_ff > {1'b0, l_ff}) begin
               fin_val_in = p1_ff;
               state_in   = ST_FIN;
            end else begin
               phase_in = PH_REC;
               // divisor and rounding setup for this step
               den_in   = 3'(n_ff - {1'b0, m_ff});
               state_in = ST_MQ_K;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fin_val_ff;
               rsp_flag_in  = fin_flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PMM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      l_ff         <= l_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      ux_ff        <= ux_in;
      ub_ff        <= ub_in;
      xneg_ff      <= xneg_in;
      neg_ff       <= neg_in;
      dneg_ff      <= dneg_in;
      s_ff         <= s_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      fin_val_ff   <= fin_val_in;
      fin_flag_ff  <= fin_flag_in;
      mag_ff       <= mag_in;
      lo_ff        <= lo_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

/* rtl/ale_chk.sv */
// Port-level checker for the associated Legendre evaluator, bound to the top.
// Depends on ale_pkg and associated_legendre_eval_core_macros.svh.
`include "associated_legendre_eval_core_macros.svh"

module ale_chk
   import ale_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [VAL_W-1:0] rsp_value,
   input logic                    rsp_order_too_high
);

   `ALE_NEVER(a_flag_zero, clock, reset, rsp_valid && rsp_order_too_high && (rsp_value != '0), "flagged item carries nonzero value")
   `ALE_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "accepted a second item while busy")
   `ALE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)), "stalled result changed")
   `ALE_ASSERT(a_reset_quiet, clock, 1'b0, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind associated_legendre_eval_core ale_chk u_ale_chk (.*);

/* tb/tb.sv */
// Self-checking bench for associated_legendre_eval_core: directed and random items,
// each predicted with an independent fixed-point model of P_l^m(x).
// Depends on ale_pkg and the core RTL.
module tb;
   import ale_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [DEG_W-1:0]        req_degree;
   logic [DEG_W-1:0]        req_order;
   logic signed [X_W-1:0]   req_cos_theta;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_order_too_high;

   localparam logic signed [X_W-1:0] X_ONE = 32'sd1073741824;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    too_high;
   } legendre_type;

   legendre_type pending_q[$];
   int           fail_count;
   longint       cycle_count;
   bit           rsp_hold;      // long receiver hold-off request
   bit           quiet;         // no random idling on either side

   associated_legendre_eval_core u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint clip48(longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
   endfunction

   // (a*b)>>30, round half away from zero; 128-bit exact product
   function automatic longint q30_mul(longint a, longint b);
      logic [127:0] ua, ub, prod;
      bit           neg;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? -a : a;
      ub   = (b < 0) ? -b : b;
      prod = (ua * ub + (128'd1 << 29)) >> 30;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint un, q;
      un = (num < 0) ? -num : num;
      q  = (un + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic legendre_type legendre_predict(logic [2:0] l_in, logic [2:0] m_in,
                                                      logic signed [31:0] x_in);
      legendre_type r;
      longint       l, m, x, s, p0, p1, pn, t1, t2;
      logic [63:0]  ax, x2, rad;
      l = l_in;
      m = m_in;
      x = x_in;
      r.too_high = 1'b0;
      if (m > l) begin
         r.value    = '0;
         r.too_high = 1'b1;
         return r;
      end
      // clamping to MAX_DEGREE is a no-op for 3-bit fields
      ax  = (x < 0) ? -x : x;
      x2  = ax * ax;
      rad = (x2 < (64'd1 << 60)) ? (64'd1 << 60) - x2 : 64'd0;
      s   = root_floor(rad);
      p0  = 64'sd1 << 28;
      for (longint n = 1; n <= m; n++) p0 = clip48(q30_mul(p0 * (2 * n - 1), s));
      if (l == m) begin
         r.value = p0[47:0];
         return r;
      end
      p1 = clip48(q30_mul(p0 * (2 * m + 1), x));
      for (longint n = m + 2; n <= l; n++) begin
         t1 = q30_mul(p1 * (2 * n - 1), x);
         t2 = p0 * (n + m - 1);
         pn = clip48(round_div(t1 - t2, n - m));
         p0 = p1;
         p1 = pn;
      end
      r.value = p1[47:0];
      return r;
   endfunction

   // ---------------- sender ----------------
   task automatic send_item(logic [2:0] l, logic [2:0] m, logic signed [31:0] x);
      while (!quiet && $urandom_range(99) < 13) @(posedge clock);
      req_valid     <= 1'b1;
      req_degree    <= l;
      req_order     <= m;
      req_cos_theta <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_q = {pending_q, legendre_predict(l, m, x)};
      req_valid <= 1'b0;
      // core is busy right after an accept, so this cycle costs nothing
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // ---------------- receiver: ready and checking ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && (quiet || $urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      legendre_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            exp_r = pending_q.pop_front();
            if (rsp_value !== exp_r.value) begin
               $error("value: expected %0d got %0d", exp_r.value, rsp_value);
               fail_count++;
            end
            if (rsp_order_too_high !== exp_r.too_high) begin
               $error("order_too_high: expected %0b got %0b", exp_r.too_high,
                      rsp_order_too_high);
               fail_count++;
            end
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- tests ----------------
   function automatic logic signed [31:0] rand_x();
      case ($urandom_range(5))
         0:       return X_ONE;
         1:       return -X_ONE;
         2:       return $urandom;           // any 32-bit value; sin clamps to 0 when |x| > 1
         3:       return $signed($urandom_range(0, 20)) - 10;
         default: return $signed($urandom_range(0, 2 * 32'h4000_0000)) - X_ONE;
      endcase
   endfunction

   // extremes of every field, order above degree, |x| > 1
   task automatic test_directed();
      logic signed [31:0] xs [6];
      xs = '{X_ONE, -X_ONE, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd536870912};
      foreach (xs[i]) send_item(3'd7, 3'd0, xs[i]);
      foreach (xs[i]) send_item(3'd7, 3'd7, xs[i]);
      send_item(3'd0, 3'd0, 32'sd0);
      send_item(3'd0, 3'd7, X_ONE);
      send_item(3'd3, 3'd4, -X_ONE);
      send_item(3'd1, 3'd0, -32'sd1);
      send_item(3'd7, 3'd6, 32'sd5);
      send_item(3'd5, 3'd2, 32'sh4000_0001);
      send_item(3'd6, 3'd3, 32'shC000_0000);
      drain_results();
   endtask

   task automatic test_random(int count);
      logic [2:0] l, m;
      for (int i = 0; i < count; i++) begin
         l = 3'($urandom);
         m = ($urandom_range(99) < 85) ? 3'($urandom_range(0, l)) : 3'($urandom);
         send_item(l, m, rand_x());
      end
   endtask

   // receiver stalls for a long stretch while items keep coming
   task automatic test_back_pressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            rsp_hold = 1'b0;
         end
         test_random(12);
      join
      drain_results();
   endtask

   task automatic test_no_idle();
      quiet = 1'b1;
      test_random(150);
      drain_results();
      quiet = 1'b0;
   endtask

   initial begin
      fail_count    = 0;
      cycle_count   = 0;
      rsp_hold      = 1'b0;
      quiet         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_degree    = '0;
      req_order     = '0;
      req_cos_theta = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400);
      drain_results();            // sender pauses until all results are back
      test_back_pressure();
      test_no_idle();
      test_random(370);
      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // leftover expectations would be counted as failure before final report
   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT && pending_q.size() != 0) fail_count++;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/ale_pkg.sv
rtl/ale_mul32.sv
rtl/ale_isqrt.sv
rtl/ale_sdiv.sv
rtl/associated_legendre_eval_core.sv
rtl/ale_chk.sv
tb/tb.sv
